// ===== design/lti_pkg.sv =====
// ----------------------------------------------------------------------------
// lti_pkg
// Shared types, codes and helpers of the leveled time index.
// ----------------------------------------------------------------------------
package lti_pkg;

   localparam int BLOCK_LINKS_DEF = 4;
   localparam int LEVELS_DEF      = 3;
   localparam int RESULT_CAP      = 32;
   localparam int CNT_W           = $clog2(RESULT_CAP + 1);

   typedef logic [1:0] status_type;
   localparam status_type ST_ADD_OK   = 2'd0;
   localparam status_type ST_ADD_FULL = 2'd1;
   localparam status_type ST_MATCH    = 2'd2;
   localparam status_type ST_NONE     = 2'd3;

   typedef struct packed {
      logic [63:0] ltime;
      logic [63:0] chunk;
      logic [63:0] address;
   } link_type;

   typedef enum logic [2:0] {
      EMIT_ADD_OK,
      EMIT_ADD_FULL,
      EMIT_NONE,
      EMIT_PEND_MORE,
      EMIT_PEND_LAST
   } emit_type;

   typedef struct packed {
      logic     accept;
      logic     merge_init;
      logic     m_read;
      logic     m_write;
      logic     m_next;
      logic     sort_init;
      logic     s_read_i;
      logic     s_key;
      logic     s_read_j;
      logic     s_shift;
      logic     s_place;
      logic     merge_done;
      logic     push;
      logic     scan_issue;
      logic     q_select;
      logic     new_pass;
      logic     emit;
      emit_type emit_sel;
   } cmd_type;

   typedef struct packed {
      logic kind;
      logic fill0_full;
      logic reject;
      logic m_more;
      logic m_last_src;
      logic s_more;
      logic j_zero;
      logic shift_gt;
      logic scan_last;
      logic found;
      logic have_pend;
      logic cnt_cap;
      logic out_free;
   } sts_type;

   function automatic logic [2:0] ctz6(input logic [5:0] v);
      logic [2:0] r;
      r = 3'd6;
      for (int i = 5; i >= 0; i--) begin
         if (v[i]) begin
            r = 3'(i);
         end
      end
      return r;
   endfunction

endpackage

// ===== design/lti_req_if.sv =====
// ----------------------------------------------------------------------------
// lti_req_if
// Request channel: add a link or query a time range.
// ----------------------------------------------------------------------------
interface lti_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [63:0] entry_address;
   logic [63:0] entry_chunk;
   logic [63:0] entry_time;
   logic [63:0] range_from;
   logic [63:0] range_to;

   modport source (output valid, kind, entry_address, entry_chunk, entry_time,
                   range_from, range_to, input ready);
   modport sink   (input valid, kind, entry_address, entry_chunk, entry_time,
                   range_from, range_to, output ready);
endinterface

// ===== design/lti_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lti_rsp_if
// Response channel: one or more results per request.
// ----------------------------------------------------------------------------
interface lti_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [63:0] out_time;
   logic [63:0] out_chunk;
   logic [63:0] out_address;
   logic        last;

   modport source (output valid, status, out_time, out_chunk, out_address, last,
                   input ready);
   modport sink   (input valid, status, out_time, out_chunk, out_address, last,
                   output ready);
endinterface

// ===== design/lti_ctrl.sv =====
// ----------------------------------------------------------------------------
// lti_ctrl
// Sequencer: add, merge copy, insertion sort and query selection passes.
// ----------------------------------------------------------------------------
module lti_ctrl import lti_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [12:0] {
      ST_IDLE   = 13'b0000000000001,
      ST_ADD    = 13'b0000000000010,
      ST_M_RD   = 13'b0000000000100,
      ST_M_WR   = 13'b0000000001000,
      ST_S_LD   = 13'b0000000010000,
      ST_S_KEY  = 13'b0000000100000,
      ST_S_RDJ  = 13'b0000001000000,
      ST_S_CMP  = 13'b0000010000000,
      ST_PUSH   = 13'b0000100000000,
      ST_Q_SCAN = 13'b0001000000000,
      ST_Q_DRN  = 13'b0010000000000,
      ST_Q_END  = 13'b0100000000000,
      ST_Q_FIN  = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = sts.kind ? ST_Q_SCAN : ST_ADD;
            end
         end
         ST_ADD: begin
            if (!sts.fill0_full) begin
               state_in = ST_PUSH;
            end else if (sts.reject) begin
               if (sts.out_free) begin
                  cmd.emit     = 1'b1;
                  cmd.emit_sel = EMIT_ADD_FULL;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.merge_init = 1'b1;
               state_in       = ST_M_RD;
            end
         end
         ST_M_RD: begin
            if (sts.m_more) begin
               cmd.m_read = 1'b1;
               state_in   = ST_M_WR;
            end else begin
               cmd.m_next = 1'b1;
               if (sts.m_last_src) begin
                  cmd.sort_init = 1'b1;
                  state_in      = ST_S_LD;
               end
            end
         end
         ST_M_WR: begin
            cmd.m_write = 1'b1;
            state_in    = ST_M_RD;
         end
         ST_S_LD: begin
            if (sts.s_more) begin
               cmd.s_read_i = 1'b1;
               state_in     = ST_S_KEY;
            end else begin
               cmd.merge_done = 1'b1;
               state_in       = ST_PUSH;
            end
         end
         ST_S_KEY: begin
            cmd.s_key = 1'b1;
            state_in  = ST_S_RDJ;
         end
         ST_S_RDJ: begin
            if (sts.j_zero) begin
               cmd.s_place = 1'b1;
               state_in    = ST_S_LD;
            end else begin
               cmd.s_read_j = 1'b1;
               state_in     = ST_S_CMP;
            end
         end
         ST_S_CMP: begin
            if (sts.shift_gt) begin
               cmd.s_shift = 1'b1;
               state_in    = ST_S_RDJ;
            end else begin
               cmd.s_place = 1'b1;
               state_in    = ST_S_LD;
            end
         end
         ST_PUSH: begin
            if (sts.out_free) begin
               cmd.push     = 1'b1;
               cmd.emit     = 1'b1;
               cmd.emit_sel = EMIT_ADD_OK;
               state_in     = ST_IDLE;
            end
         end
         ST_Q_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_Q_DRN;
            end
         end
         ST_Q_DRN: begin
            state_in = ST_Q_END;
         end
         ST_Q_END: begin
            if (sts.out_free) begin
               if (sts.found) begin
                  cmd.q_select = 1'b1;
                  cmd.emit     = sts.have_pend;
                  cmd.emit_sel = EMIT_PEND_MORE;
                  if (sts.cnt_cap) begin
                     state_in = ST_Q_FIN;
                  end else begin
                     cmd.new_pass = 1'b1;
                     state_in     = ST_Q_SCAN;
                  end
               end else begin
                  cmd.emit     = 1'b1;
                  cmd.emit_sel = sts.have_pend ? EMIT_PEND_LAST : EMIT_NONE;
                  state_in     = ST_IDLE;
               end
            end
         end
         ST_Q_FIN: begin
            if (sts.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = EMIT_PEND_LAST;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/lti_dpath.sv =====
// ----------------------------------------------------------------------------
// lti_dpath
// Link memory, level fill counts, merge and sort pointers, query selection
// and the response register.
// ----------------------------------------------------------------------------
module lti_dpath import lti_pkg::*; #(
   parameter int BLOCK_LINKS = BLOCK_LINKS_DEF,
   parameter int LEVELS      = LEVELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic        kind,
   input  logic [63:0] entry_address,
   input  logic [63:0] entry_chunk,
   input  logic [63:0] entry_time,
   input  logic [63:0] range_from,
   input  logic [63:0] range_to,
   lti_rsp_if.source   rsp
);

   localparam int SLOTS = BLOCK_LINKS << LEVELS;
   localparam int AW    = $clog2(SLOTS);
   localparam int LW    = $clog2(LEVELS + 1);

   function automatic logic [AW-1:0] lvl_base(input int s);
      return (s == 0) ? '0 : AW'(BLOCK_LINKS << (s - 1));
   endfunction

   function automatic logic [AW-1:0] lvl_cap(input int s);
      return (s == 0) ? AW'(BLOCK_LINKS) : AW'(BLOCK_LINKS << (s - 1));
   endfunction

   link_type mem_q [SLOTS];
   link_type rd_data_ff;

   logic [AW-1:0] fill_ff [LEVELS+1];
   logic [4:0]    mc_ff;
   logic [LW-1:0] ts_ff, src_ff;
   logic [AW-1:0] idx_ff, si_ff, sj_ff, scan_addr_ff, cmp_slot_ff;
   logic [AW-1:0] prev_slot_ff, best_slot_ff;
   logic          cmp_valid_ff, have_prev_ff, found_ff, have_pend_ff, out_valid_ff;
   logic [CNT_W-1:0] cnt_ff;
   link_type      in_link_ff, key_ff, best_ff, pend_ff, out_link_ff;
   logic [63:0]   from_ff, to_ff, prev_t_ff;
   status_type    out_status_ff;
   logic          out_last_ff;

   logic [5:0]    nxt;
   logic [2:0]    tgt;
   logic          reject;
   logic [AW-1:0] sort_base, src_base, ts_cap, rd_addr, wr_addr;
   logic          rd_en, wr_en, tgt_room, slot_filled, take;
   link_type      wr_data;

   assign nxt       = {1'b0, mc_ff} + 6'd1;
   assign tgt       = ctz6(nxt);
   assign reject    = (int'(tgt) >= LEVELS) ||
                      ((int'(tgt) == LEVELS - 1) && (fill_ff[LEVELS] >= lvl_cap(LEVELS)));
   assign sort_base = lvl_base(int'(ts_ff));
   assign src_base  = lvl_base(int'(src_ff));
   assign ts_cap    = lvl_cap(int'(ts_ff));
   assign tgt_room  = fill_ff[ts_ff] < ts_cap;

   always_comb begin
      rd_en   = 1'b1;
      rd_addr = scan_addr_ff;
      priority if (cmd.m_read) begin
         rd_addr = src_base + idx_ff;
      end else if (cmd.s_read_i) begin
         rd_addr = sort_base + si_ff;
      end else if (cmd.s_read_j) begin
         rd_addr = sort_base + sj_ff - AW'(1);
      end else if (cmd.scan_issue) begin
         rd_addr = scan_addr_ff;
      end else begin
         rd_en = 1'b0;
      end
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = sort_base + sj_ff;
      wr_data = rd_data_ff;
      priority if (cmd.m_write) begin
         wr_en   = tgt_room;
         wr_addr = sort_base + fill_ff[ts_ff];
      end else if (cmd.s_shift) begin
         wr_data = rd_data_ff;
      end else if (cmd.s_place) begin
         wr_data = key_ff;
      end else if (cmd.push) begin
         wr_addr = fill_ff[0];
         wr_data = in_link_ff;
      end else begin
         wr_en = 1'b0;
      end
   end

   always_comb begin
      slot_filled = 1'b0;
      for (int s = 0; s <= LEVELS; s++) begin
         if (({1'b0, scan_addr_ff} >= {1'b0, lvl_base(s)}) &&
             ({1'b0, scan_addr_ff} < ({1'b0, lvl_base(s)} + {1'b0, fill_ff[s]}))) begin
            slot_filled = 1'b1;
         end
      end
   end

   // next key after the previous pick, smallest time, earliest slot on ties
   assign take = cmp_valid_ff &&
                 (from_ff <= rd_data_ff.ltime) && (rd_data_ff.ltime <= to_ff) &&
                 (!have_prev_ff || (rd_data_ff.ltime > prev_t_ff) ||
                  ((rd_data_ff.ltime == prev_t_ff) && (cmp_slot_ff > prev_slot_ff))) &&
                 (!found_ff || (rd_data_ff.ltime < best_ff.ltime));

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_q[rd_addr];
      end
      if (wr_en) begin
         mem_q[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= LEVELS; s++) begin
            fill_ff[s] <= '0;
         end
         mc_ff        <= '0;
         ts_ff        <= '0;
         src_ff       <= '0;
         idx_ff       <= '0;
         si_ff        <= '0;
         sj_ff        <= '0;
         scan_addr_ff <= '0;
         cmp_valid_ff <= 1'b0;
         have_prev_ff <= 1'b0;
         found_ff     <= 1'b0;
         have_pend_ff <= 1'b0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cmp_valid_ff <= cmd.scan_issue && slot_filled;
         if (cmd.merge_init) begin
            ts_ff  <= LW'(4'(tgt) + 4'd1);
            src_ff <= '0;
            idx_ff <= '0;
         end
         if (cmd.m_write) begin
            idx_ff <= idx_ff + AW'(1);
            if (tgt_room) begin
               fill_ff[ts_ff] <= fill_ff[ts_ff] + AW'(1);
            end
         end
         if (cmd.m_next) begin
            fill_ff[src_ff] <= '0;
            src_ff          <= src_ff + LW'(1);
            idx_ff          <= '0;
         end
         if (cmd.sort_init) begin
            si_ff <= AW'(1);
         end
         if (cmd.s_key) begin
            sj_ff <= si_ff;
         end
         if (cmd.s_shift) begin
            sj_ff <= sj_ff - AW'(1);
         end
         if (cmd.s_place) begin
            si_ff <= si_ff + AW'(1);
         end
         if (cmd.merge_done) begin
            mc_ff <= mc_ff + 5'd1;
         end
         if (cmd.push) begin
            fill_ff[0] <= fill_ff[0] + AW'(1);
         end
         if (cmd.accept) begin
            have_prev_ff <= 1'b0;
            have_pend_ff <= 1'b0;
            cnt_ff       <= '0;
         end
         if (cmd.accept || cmd.new_pass) begin
            scan_addr_ff <= '0;
            found_ff     <= 1'b0;
         end else if (cmd.scan_issue) begin
            scan_addr_ff <= scan_addr_ff + AW'(1);
         end
         if (take) begin
            found_ff <= 1'b1;
         end
         if (cmd.q_select) begin
            have_prev_ff <= 1'b1;
            have_pend_ff <= 1'b1;
            cnt_ff       <= cnt_ff + CNT_W'(1);
         end
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         in_link_ff <= '{ltime: entry_time, chunk: entry_chunk, address: entry_address};
         from_ff    <= range_from;
         to_ff      <= range_to;
      end
      if (cmd.s_key) begin
         key_ff <= rd_data_ff;
      end
      cmp_slot_ff <= scan_addr_ff;
      if (take) begin
         best_ff      <= rd_data_ff;
         best_slot_ff <= cmp_slot_ff;
      end
      if (cmd.q_select) begin
         pend_ff      <= best_ff;
         prev_t_ff    <= best_ff.ltime;
         prev_slot_ff <= best_slot_ff;
      end
      if (cmd.emit) begin
         unique case (cmd.emit_sel)
            EMIT_ADD_OK: begin
               out_status_ff <= ST_ADD_OK;
               out_link_ff   <= '0;
               out_last_ff   <= 1'b1;
            end
            EMIT_ADD_FULL: begin
               out_status_ff <= ST_ADD_FULL;
               out_link_ff   <= '0;
               out_last_ff   <= 1'b1;
            end
            EMIT_PEND_MORE: begin
               out_status_ff <= ST_MATCH;
               out_link_ff   <= pend_ff;
               out_last_ff   <= 1'b0;
            end
            EMIT_PEND_LAST: begin
               out_status_ff <= ST_MATCH;
               out_link_ff   <= pend_ff;
               out_last_ff   <= 1'b1;
            end
            default: begin
               out_status_ff <= ST_NONE;
               out_link_ff   <= '0;
               out_last_ff   <= 1'b1;
            end
         endcase
      end
   end

   assign sts.kind       = kind;
   assign sts.fill0_full = fill_ff[0] >= lvl_cap(0);
   assign sts.reject     = reject;
   assign sts.m_more     = idx_ff < fill_ff[src_ff];
   assign sts.m_last_src = (src_ff + LW'(1)) == ts_ff;
   assign sts.s_more     = si_ff < fill_ff[ts_ff];
   assign sts.j_zero     = (sj_ff == '0);
   assign sts.shift_gt   = rd_data_ff.ltime > key_ff.ltime;
   assign sts.scan_last  = (scan_addr_ff == AW'(SLOTS - 1));
   assign sts.found      = found_ff;
   assign sts.have_pend  = have_pend_ff;
   assign sts.cnt_cap    = (cnt_ff == CNT_W'(RESULT_CAP - 1));
   assign sts.out_free   = !out_valid_ff || rsp.ready;

   assign rsp.valid       = out_valid_ff;
   assign rsp.status      = out_status_ff;
   assign rsp.out_time    = out_link_ff.ltime;
   assign rsp.out_chunk   = out_link_ff.chunk;
   assign rsp.out_address = out_link_ff.address;
   assign rsp.last        = out_last_ff;

endmodule

// ===== design/leveled_time_index_unit.sv =====
// ----------------------------------------------------------------------------
// leveled_time_index_unit
// Time-keyed link index kept as a lookahead array of sorted levels.
// ----------------------------------------------------------------------------
// One request at a time, all links in one single-port memory of
// BLOCK_LINKS << LEVELS entries. An add that fits level 0 only writes the
// link there; an add that merges copies every link of the source levels
// into the target level, then insertion-sorts the target level in place.
// A query runs one scan of all slots per returned link plus one closing
// scan, which is skipped once RESULT_CAP links are found. A response that
// is not taken stalls the sequence until the response register frees. The
// response register lets a new request enter while the last result still
// waits.
module leveled_time_index_unit import lti_pkg::*; #(
   parameter int BLOCK_LINKS = BLOCK_LINKS_DEF,
   parameter int LEVELS      = LEVELS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   lti_req_if.sink   req_port,
   lti_rsp_if.source rsp_port
);

   cmd_type cmd;
   sts_type sts;
   logic    req_ready;

   assign req_port.ready = req_ready;

   lti_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lti_dpath #(
      .BLOCK_LINKS (BLOCK_LINKS),
      .LEVELS      (LEVELS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .kind          (req_port.kind),
      .entry_address (req_port.entry_address),
      .entry_chunk   (req_port.entry_chunk),
      .entry_time    (req_port.entry_time),
      .range_from    (req_port.range_from),
      .range_to      (req_port.range_to),
      .rsp           (rsp_port)
   );

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_port.valid || rsp_port.ready))
      else $error("response register overwritten");

   a_add_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && (rsp_port.status == ST_ADD_OK || rsp_port.status == ST_ADD_FULL ||
                          rsp_port.status == ST_NONE)) |-> rsp_port.last)
      else $error("single-result response without last");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_port.valid && req_port.ready) |=> !req_port.ready)
      else $error("request taken while busy");

endmodule

// ===== tb/sv/lti_result_checker.sv =====
// ----------------------------------------------------------------------------
// lti_result_checker
// Watches both channels of the leveled time index, keeps its own copy of the
// levels, predicts every result of each request transfer and compares the
// response transfers against them in order.
// ----------------------------------------------------------------------------
module lti_result_checker import lti_pkg::*; (
   input  logic clock,
   input  logic reset,
   lti_req_if   req_mon,
   lti_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BL    = BLOCK_LINKS_DEF;
   localparam int LV    = LEVELS_DEF;
   localparam int SLOTS = BL << LV;

   typedef struct packed {
      status_type  status;
      link_type    link;
      logic        last;
   } result_type;

   result_type  index_results[$];
   link_type    slots[SLOTS];
   logic [5:0]  fill[LV + 1];
   logic [63:0] lo_time[LV + 1];
   logic [63:0] hi_time[LV + 1];
   logic [4:0]  merges;
   logic        full;

   function automatic int level_cap(int s);
      return s == 0 ? BL : BL << (s - 1);
   endfunction

   function automatic int level_base(int s);
      return s == 0 ? 0 : BL << (s - 1);
   endfunction

   function automatic void queue_result(status_type st, link_type l, logic lst);
      result_type r;
      r.status = st;
      r.link   = l;
      r.last   = lst;
      index_results.insert(index_results.size(), r);
   endfunction

   task automatic clear_level(int s);
      for (int i = 0; i < level_cap(s); i++) slots[level_base(s) + i] = '0;
      fill[s] = '0;
      lo_time[s] = '1;
      hi_time[s] = '0;
   endtask

   task automatic push_link(int s, link_type l, output bit ok);
      ok = fill[s] < level_cap(s);
      if (ok) begin
         slots[level_base(s) + fill[s]] = l;
         fill[s]++;
         if (l.ltime > hi_time[s]) hi_time[s] = l.ltime;
         if (l.ltime < lo_time[s]) lo_time[s] = l.ltime;
      end
   endtask

   // insertion sort: equal times keep their order
   task automatic order_by_time(ref link_type v[$]);
      link_type k;
      int j;
      for (int i = 1; i < v.size(); i++) begin
         k = v[i];
         j = i;
         while (j > 0 && v[j - 1].ltime > k.ltime) begin
            v[j] = v[j - 1];
            j--;
         end
         v[j] = k;
      end
   endtask

   task automatic merge_down(output bit ok);
      logic [5:0] nxt;
      int tgt, ts;
      bit dummy;
      link_type run[$];
      nxt = 6'(merges) + 6'd1;
      tgt = 0;
      while (tgt < 6 && !nxt[tgt]) tgt++;
      ts = tgt + 1;
      if (tgt >= LV || (tgt == LV - 1 && fill[ts] >= level_cap(ts))) begin
         full = 1'b1;
         ok = 1'b0;
      end else begin
         for (int s = 0; s <= tgt; s++) begin
            for (int i = 0; i < fill[s]; i++) push_link(ts, slots[level_base(s) + i], dummy);
            clear_level(s);
         end
         for (int i = 0; i < fill[ts]; i++) run.insert(run.size(), slots[level_base(ts) + i]);
         order_by_time(run);
         foreach (run[i]) slots[level_base(ts) + i] = run[i];
         merges++;
         ok = 1'b1;
      end
   endtask

   task automatic predict_index_step(logic kind, link_type l, logic [63:0] from,
                                     logic [63:0] upto);
      bit ok;
      link_type hits[$];
      link_type t;
      logic [63:0] lo, hi;
      if (kind == 1'b0) begin
         ok = 1'b1;
         if (fill[0] >= level_cap(0)) merge_down(ok);
         if (ok) push_link(0, l, ok);
         queue_result(ok ? ST_ADD_OK : ST_ADD_FULL, '0, 1'b1);
      end else begin
         for (int s = 0; s <= LV; s++) begin
            lo = lo_time[s];
            hi = hi_time[s];
            if (fill[s] == 0) continue;
            if (!((from <= hi && hi <= upto) || (from <= lo && lo <= upto) ||
                  (lo <= from && from <= hi) || (lo <= upto && upto <= hi))) continue;
            for (int i = 0; i < fill[s]; i++) begin
               t = slots[level_base(s) + i];
               if (from <= t.ltime && t.ltime <= upto && hits.size() < SLOTS)
                  hits.insert(hits.size(), t);
            end
         end
         if (hits.size() == 0) begin
            queue_result(ST_NONE, '0, 1'b1);
         end else begin
            order_by_time(hits);
            while (hits.size() > RESULT_CAP) void'(hits.pop_back());
            foreach (hits[i])
               queue_result(ST_MATCH, hits[i], i == hits.size() - 1);
         end
      end
   endtask

   task automatic report(string what, logic [63:0] want, logic [63:0] got);
      $display("%0t: %s expected %h got %h", $realtime, what, want, got);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending_count = 0;
      for (int s = 0; s <= LV; s++) clear_level(s);
      merges = '0;
      full = 1'b0;
   end

   always @(posedge clock) begin
      result_type e;
      if (!reset) begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (index_results.size() == 0) begin
               report("unexpected transfer, status", '0, rsp_mon.status);
            end else begin
               e = index_results.pop_front();
               if (rsp_mon.status !== e.status) report("status", e.status, rsp_mon.status);
               if (rsp_mon.out_time !== e.link.ltime)
                  report("out_time", e.link.ltime, rsp_mon.out_time);
               if (rsp_mon.out_chunk !== e.link.chunk)
                  report("out_chunk", e.link.chunk, rsp_mon.out_chunk);
               if (rsp_mon.out_address !== e.link.address)
                  report("out_address", e.link.address, rsp_mon.out_address);
               if (rsp_mon.last !== e.last) report("last", e.last, rsp_mon.last);
            end
         end
         if (req_mon.valid && req_mon.ready)
            predict_index_step(req_mon.kind,
                               '{req_mon.entry_time, req_mon.entry_chunk,
                                 req_mon.entry_address},
                               req_mon.range_from, req_mon.range_to);
      end
      pending_count = index_results.size();
   end

   final begin
      if (index_results.size() != 0)
         $display("%0d expected results never arrived", index_results.size());
   end
endmodule

// ===== tb/sv/tb_leveled_time_index_unit.sv =====
// ----------------------------------------------------------------------------
// tb_leveled_time_index_unit
// Drives adds and time-range queries into the leveled time index with random
// gaps and back-pressure; the checker beside the block judges every result.
// ----------------------------------------------------------------------------
module tb_leveled_time_index_unit import lti_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT = 1_000_000;

   logic clock;
   logic reset;
   logic calm;
   logic hold_req;
   int   fail_count;
   int   pending_count;
   int   cycles;
   int   hold_left;

   lti_req_if req_port ();
   lti_rsp_if rsp_port ();

   leveled_time_index_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port.sink),
      .rsp_port (rsp_port.source)
   );

   lti_result_checker scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_port),
      .rsp_mon       (rsp_port),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // response side: random stalls plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_req && hold_left < 0) begin
         hold_left <= 600;
         rsp_port.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_port.ready <= 1'b0;
      end else begin
         rsp_port.ready <= calm || $urandom_range(99) >= 18;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] rand_time();
      case ($urandom_range(9))
         0: return rand64();
         1: return '1;
         default: return 64'($urandom_range(40));
      endcase
   endfunction

   task automatic send(logic kind, logic [63:0] t, logic [63:0] from, logic [63:0] upto);
      req_port.valid <= 1'b1;
      req_port.kind <= kind;
      req_port.entry_time <= t;
      req_port.entry_chunk <= rand64();
      req_port.entry_address <= rand64();
      req_port.range_from <= from;
      req_port.range_to <= upto;
      @(posedge clock);
      while (!req_port.ready) @(posedge clock);
      if (!calm && $urandom_range(99) < 18) begin
         req_port.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic add_link(logic [63:0] t);
      send(1'b0, t, rand64(), rand64());
   endtask

   task automatic query(logic [63:0] from, logic [63:0] upto);
      send(1'b1, rand64(), from, upto);
   endtask

   task automatic random_query();
      logic [63:0] a;
      a = 64'($urandom_range(40));
      case ($urandom_range(5))
         0: query(rand64(), rand64());
         1: query('0, '1);
         2: query(a + 64'($urandom_range(5)), a);
         default: query(a, a + 64'($urandom_range(12)));
      endcase
   endtask

   task automatic drain();
      req_port.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      cycles = 0;
      hold_left = -1;
      hold_req = 1'b0;
      calm = 1'b0;
      reset = 1'b1;
      req_port.valid = 1'b0;
      req_port.kind = 1'b0;
      req_port.entry_time = '0;
      req_port.entry_chunk = '0;
      req_port.entry_address = '0;
      req_port.range_from = '0;
      req_port.range_to = '0;
      rsp_port.ready = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty index, extreme times, ties, reversed and exact ranges
      query('0, '1);
      add_link('0);
      add_link('1);
      add_link(64'd7);
      add_link(64'd7);
      query('0, '1);
      add_link(64'd3);
      add_link(64'd7);
      query(64'd7, 64'd7);
      query(64'd8, 64'd3);
      query('1, '1);
      query('0, '0);
      query(64'd100, 64'd200);
      add_link(64'h8000_0000_0000_0000);
      add_link(64'd1);
      query(64'd1, 64'hffff_ffff_ffff_fffe);
      drain();

      // random: fill the levels first, then mostly queries
      for (int n = 0; n < 130; n++) begin
         calm = n >= 60 && n < 95;
         if (n == 40) hold_req <= 1'b1;
         if (n == 100) drain();
         if ($urandom_range(99) < (n < 45 ? 75 : 25)) add_link(rand_time());
         else random_query();
      end
      drain();
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
